/* rtl/ped_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types and defaults for the pairwise Euclidean distance block.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int IDX_OUT_W = 6;
    localparam int DIST_W    = 25;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic               restart;
    } in_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] new_index;
        logic [IDX_OUT_W-1:0] old_index;
        logic [DIST_W-1:0]    distance;
        logic                 last;
        logic                 overflow;
    } out_item_t;

    // Per-result tag that rides along the pipeline
    typedef struct packed {
        logic [IDX_OUT_W-1:0] new_index;
        logic [IDX_OUT_W-1:0] old_index;
        logic                 last;
        logic                 overflow;
    } tag_t;

endpackage

/* rtl/ped_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ped_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* rtl/ped_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ped_cell
// One square root cell: takes the next bit pair of the radicand and works out
// one root bit, then hands remainder, root and radicand to the next cell.
// ----------------------------------------------------------------------------
module ped_cell
    import ped_pkg::*;
#(
    parameter int NPAIR = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 valid_in,
    input  tag_t                 tag_in,
    input  logic [NPAIR+1:0]     rem_in,
    input  logic [NPAIR-1:0]     root_in,
    input  logic [2*NPAIR-1:0]   val_in,
    output logic                 valid_out,
    output tag_t                 tag_out,
    output logic [NPAIR+1:0]     rem_out,
    output logic [NPAIR-1:0]     root_out,
    output logic [2*NPAIR-1:0]   val_out
);

    localparam int RW = NPAIR + 2;
    localparam int VW = 2 * NPAIR;

    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;

    // Bring down the next pair and try the next root bit
    assign cur   = {rem_in[RW-3:0], val_in[VW-1:VW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out <= 1'b0;
        end else if (adv) begin
            valid_out <= valid_in;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_out  <= tag_in;
            rem_out  <= ge ? (cur - trial) : cur;
            root_out <= {root_in[NPAIR-2:0], ge};
            val_out  <= {val_in[VW-3:0], 2'b00};
        end
    end

endmodule

/* rtl/pairwise_euclidean_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_euclidean_distance
// Streams the lower triangle of a distance matrix, one new point per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one point per item. Point n of a set gives
//   n results on m_valid/m_ready/m_item, old_index 0..n-1, last set on the
//   final one. The first point of a set gives no result. restart starts a
//   new set with this point as index zero. A point that arrives with the
//   store full gives one result with overflow set and is dropped.
//   Distances come from a chain of square root cells, one root bit per cell
//   (COORD_BITS + 1 + FRAC_BITS cells, 25 by default) after a read, a
//   difference, a multiply and an add stage. The sequencer issues one store
//   read per cycle while the chain is not held; s_ready is high only while
//   nothing is being issued. Within a row, results come out one per cycle
//   while the chain is not held. When m_valid is high and m_ready is low
//   the whole chain holds. Reset empties the set and clears all valid
//   flags; the point store itself is not cleared.
// ----------------------------------------------------------------------------
module pairwise_euclidean_distance
    import ped_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int C     = COORD_BITS;
    localparam int SUM_W = 2 * C + 1;
    localparam int NPAIR = (SUM_W + 1) / 2 + FRAC_BITS;
    localparam int VW    = 2 * NPAIR;
    localparam int RW    = NPAIR + 2;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic             state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] n_reg;
    logic [IDX_W-1:0] j_reg;
    logic             ovf_reg;
    logic [C-1:0]     x_reg;
    logic [C-1:0]     y_reg;

    logic             adv;
    logic             accept;
    logic             issue;
    logic             last_issue;
    logic [C-1:0]     x_in;
    logic [C-1:0]     y_in;
    logic [CNT_W-1:0] base;
    logic             full;

    assign adv     = !m_valid || m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign x_in    = C'($unsigned(s_item.x_coord));
    assign y_in    = C'($unsigned(s_item.y_coord));
    assign base    = s_item.restart ? '0 : count_reg;
    assign full    = (base == CNT_W'(MAX_POINTS));
    assign issue   = (state_reg == ST_BUSY) && adv;
    assign last_issue = ovf_reg || (j_reg == n_reg - IDX_W'(1));

    // Sequencer: take a point, then walk the earlier points
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else if (accept) begin
            if (full) begin
                state_reg <= ST_BUSY;
            end else begin
                count_reg <= base + CNT_W'(1);
                state_reg <= (base != '0) ? ST_BUSY : ST_IDLE;
            end
        end else if (issue && last_issue) begin
            state_reg <= ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= x_in;
            y_reg   <= y_in;
            j_reg   <= '0;
            ovf_reg <= full;
            n_reg   <= full ? '0 : base[IDX_W-1:0];
        end else if (issue) begin
            j_reg <= j_reg + IDX_W'(1);
        end
    end

    // Point store
    logic [2*C-1:0] rdata;

    ped_ram #(
        .WIDTH (2 * C),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (accept && !full),
        .waddr (base[IDX_W-1:0]),
        .wdata ({x_in, y_in}),
        .re    (adv),
        .raddr (j_reg),
        .rdata (rdata)
    );

    // Stage 1: align with read data
    logic         v1_reg, v2_reg, v3_reg, v4_reg;
    tag_t         tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [C-1:0] x1_reg, y1_reg;
    tag_t         tag0;

    assign tag0.new_index = IDX_OUT_W'(n_reg);
    assign tag0.old_index = IDX_OUT_W'(j_reg);
    assign tag0.last      = last_issue;
    assign tag0.overflow  = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage 2: absolute differences
    logic signed [C:0] ddx, ddy;
    logic        [C:0] mdx, mdy;
    logic [C-1:0]      dx_reg, dy_reg;

    assign ddx = $signed({x1_reg[C-1], x1_reg}) - $signed({rdata[2*C-1], rdata[2*C-1:C]});
    assign ddy = $signed({y1_reg[C-1], y1_reg}) - $signed({rdata[C-1], rdata[C-1:0]});
    assign mdx = ddx[C] ? (~ddx + 1'b1) : ddx;
    assign mdy = ddy[C] ? (~ddy + 1'b1) : ddy;

    // Stage 3: squares, stage 4: sum
    logic [2*C-1:0]   sx_reg, sy_reg;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_reg;

    assign sum = SUM_W'(sx_reg) + SUM_W'(sy_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg <= tag0;
            x1_reg   <= x_reg;
            y1_reg   <= y_reg;
            tag2_reg <= tag1_reg;
            dx_reg   <= tag1_reg.overflow ? '0 : C'(mdx);
            dy_reg   <= tag1_reg.overflow ? '0 : C'(mdy);
            tag3_reg <= tag2_reg;
            sx_reg   <= dx_reg * dx_reg;
            sy_reg   <= dy_reg * dy_reg;
            tag4_reg <= tag3_reg;
            sum_reg  <= sum;
        end
    end

    // Square root chain
    logic             cv    [NPAIR+1];
    tag_t             ctag  [NPAIR+1];
    logic [RW-1:0]    crem  [NPAIR+1];
    logic [NPAIR-1:0] croot [NPAIR+1];
    logic [VW-1:0]    cval  [NPAIR+1];

    assign cv[0]    = v4_reg;
    assign ctag[0]  = tag4_reg;
    assign crem[0]  = '0;
    assign croot[0] = '0;
    assign cval[0]  = VW'(sum_reg) << (2 * FRAC_BITS);

    for (genvar k = 0; k < NPAIR; k++) begin : g_cell
        ped_cell #(
            .NPAIR (NPAIR)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (cv[k]),
            .tag_in    (ctag[k]),
            .rem_in    (crem[k]),
            .root_in   (croot[k]),
            .val_in    (cval[k]),
            .valid_out (cv[k+1]),
            .tag_out   (ctag[k+1]),
            .rem_out   (crem[k+1]),
            .root_out  (croot[k+1]),
            .val_out   (cval[k+1])
        );
    end

    // Output from the last cell
    assign m_valid          = cv[NPAIR];
    assign m_item.new_index = ctag[NPAIR].new_index;
    assign m_item.old_index = ctag[NPAIR].old_index;
    assign m_item.distance  = DIST_W'(croot[NPAIR]);
    assign m_item.last      = ctag[NPAIR].last;
    assign m_item.overflow  = ctag[NPAIR].overflow;

endmodule
